FILE: rtl/rambo1_pkg.sv
// ----------------------------------------------------------------------------
// RAMBO-1 mapper package
// Shared types and constants for the bank switch mapper: function codes,
// bus addresses, command codes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rambo1_pkg;

  // Slot counts and widths
  localparam int CHR_SLOTS   = 8;
  localparam int CHR_SEL_W   = $clog2(CHR_SLOTS);
  localparam int PRG_SLOTS   = 4;
  localparam int PRG_SEL_W   = $clog2(PRG_SLOTS);
  localparam int PAGE_W      = 9;
  localparam int CHR_CNT_W   = 11;
  localparam int PRG_CNT_W   = 9;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 16;
  localparam int CMD_W       = 4;

  // Program slots come out of reset on the last page of the default image.
  localparam logic [PAGE_W-1:0] PRG_RESET_PAGE = 9'd31;

  // Transaction function codes
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_CPU_MAP = 2'd1;
  localparam logic [1:0] FUNC_PPU_MAP = 2'd2;

  // Bus decode
  localparam logic [ADDR_W-1:0] ADDR_SELECT  = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_DATA    = 16'h8001;
  localparam logic [ADDR_W-1:0] ADDR_MIRROR  = 16'hA000;
  localparam logic [ADDR_W-1:0] MIRROR_MASK  = 16'hF000;

  // Bit positions in the select byte
  localparam int SEL_PRG_SWAP_BIT = 6;
  localparam int SEL_CHR_SWAP_BIT = 7;

  // Configuration register indexes
  localparam logic CFG_CHR_COUNT = 1'b0;
  localparam logic CFG_PRG_COUNT = 1'b1;

  // Bank commands
  localparam logic [CMD_W-1:0] CMD_CHR_PAIR_LO = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CHR_PAIR_HI = 4'd1;
  localparam logic [CMD_W-1:0] CMD_CHR_SINGLE0 = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CHR_SINGLE1 = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CHR_SINGLE2 = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CHR_SINGLE3 = 4'd5;
  localparam logic [CMD_W-1:0] CMD_PRG_FIRST   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_PRG_SECOND  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CHR_ODD1    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CHR_ODD3    = 4'd9;
  localparam logic [CMD_W-1:0] CMD_PRG_THIRD   = 4'd15;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PAIR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/rambo1_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// RAMBO-1 bank switch mapper
// Holds the character and program bank registers of the cartridge, takes
// CPU bus writes and answers CPU and PPU address translations.
// ----------------------------------------------------------------------------
// Every transaction yields one result. Translations and bus writes that do
// not load a bank go from acceptance through the done state to the output
// register. A bank data write at 0x8001 reduces the byte modulo the page
// count with one compare-subtract unit, one quotient bit per cycle, in the
// divide state, then visits the pair state when a command also fills the
// neighboring slot with the next page (the same unit wraps that page). The
// input is not ready while a transaction is in the sequencer; a finished
// result waits in the output register without holding up the next transaction.
`default_nettype none

module rambo1_bank_switch_mapper (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // func[1:0], address[17:2], data[25:18]
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // page[8:0], mirroring[9]
);
  import rambo1_pkg::*;

  // Configuration and mapper state
  logic [CHR_CNT_W-1:0] chr_page_count;
  logic [PRG_CNT_W-1:0] prg_page_count;
  logic [CMD_W-1:0]     command_index;
  logic                 prg_swap;
  logic                 chr_swap;
  logic                 mirror_bit;
  logic [PAGE_W-1:0]    chr_slot_page [CHR_SLOTS];
  logic [PAGE_W-1:0]    prg_slot_page [PRG_SLOTS];

  // Sequencer and datapath registers
  state_t               state;
  state_t               state_next;
  logic [CHR_CNT_W-1:0] div_cnt;
  logic [BYTE_W-1:0]    dividend;
  logic [BYTE_W-1:0]    rem;
  logic [2:0]           step;
  logic                 is_prg;
  logic [CHR_SEL_W-1:0] slot;
  logic                 pair;
  logic [PAGE_W-1:0]    res_page;

  // Input fields
  logic [1:0]        in_func;
  logic [ADDR_W-1:0] in_addr;
  logic [BYTE_W-1:0] in_data;
  logic              in_accept;
  logic              out_load;

  assign in_func   = s_tdata[1:0];
  assign in_addr   = s_tdata[17:2];
  assign in_data   = s_tdata[25:18];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // Command decode: which slot the data write targets
  logic                 dec_hit;
  logic                 dec_prg;
  logic                 dec_pair;
  logic [CHR_SEL_W-1:0] dec_slot;
  logic [CHR_CNT_W-1:0] dec_cnt;
  logic                 start_div;

  always_comb begin
    dec_hit  = 1'b1;
    dec_prg  = 1'b0;
    dec_pair = 1'b0;
    dec_slot = '0;
    unique case (command_index)
      CMD_CHR_PAIR_LO: begin
        dec_slot = {chr_swap, 2'b00};
        dec_pair = 1'b1;
      end
      CMD_CHR_PAIR_HI: begin
        dec_slot = {chr_swap, 2'b10};
        dec_pair = 1'b1;
      end
      CMD_CHR_SINGLE0: dec_slot = {~chr_swap, 2'b00};
      CMD_CHR_SINGLE1: dec_slot = {~chr_swap, 2'b01};
      CMD_CHR_SINGLE2: dec_slot = {~chr_swap, 2'b10};
      CMD_CHR_SINGLE3: dec_slot = {~chr_swap, 2'b11};
      CMD_PRG_FIRST: begin
        dec_prg  = 1'b1;
        dec_slot = prg_swap ? 3'd1 : 3'd0;
      end
      CMD_PRG_SECOND: begin
        dec_prg  = 1'b1;
        dec_slot = prg_swap ? 3'd2 : 3'd1;
      end
      CMD_CHR_ODD1: dec_slot = 3'd1;
      CMD_CHR_ODD3: dec_slot = 3'd3;
      CMD_PRG_THIRD: begin
        dec_prg  = 1'b1;
        dec_slot = prg_swap ? 3'd0 : 3'd2;
      end
      default: dec_hit = 1'b0;
    endcase
    dec_cnt   = dec_prg ? {2'b00, prg_page_count} : chr_page_count;
    start_div = (in_func == FUNC_WRITE) && (in_addr == ADDR_DATA) && dec_hit &&
                (dec_cnt != '0);
  end

  // Shared compare-subtract unit: remainder steps and the pair wrap
  logic [PAGE_W-1:0] unit_a;
  logic [11:0]       unit_diff;
  logic              unit_ge;
  logic [PAGE_W-1:0] unit_res;

  always_comb begin
    if (state == ST_PAIR) begin
      unit_a = {1'b0, rem} + 9'd1;
    end else begin
      unit_a = {rem, dividend[BYTE_W-1]};
    end
    unit_diff = {3'b000, unit_a} - {1'b0, div_cnt};
    unit_ge   = !unit_diff[11];
    unit_res  = unit_ge ? unit_diff[PAGE_W-1:0] : unit_a;
  end

  // Translation lookup
  logic [PAGE_W-1:0] map_page;

  always_comb begin
    map_page = '0;
    if (in_func == FUNC_CPU_MAP) begin
      if (in_addr[15]) begin
        map_page = prg_slot_page[in_addr[14:13]];
      end
    end else if (in_func == FUNC_PPU_MAP) begin
      map_page = chr_slot_page[in_addr[12:10]];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output load
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = start_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (step == 3'd7) begin
          state_next = pair ? ST_PAIR : ST_DONE;
        end
      end
      ST_PAIR: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chr_page_count <= 11'd256;
      prg_page_count <= 9'd32;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CHR_COUNT) begin
        chr_page_count <= cfg_data;
      end else begin
        prg_page_count <= cfg_data[PRG_CNT_W-1:0];
      end
    end
  end

  // Mapper state and bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      command_index <= '0;
      prg_swap      <= 1'b0;
      chr_swap      <= 1'b0;
      mirror_bit    <= 1'b0;
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_slot_page[i] <= PAGE_W'(i);
      end
      for (int i = 0; i < PRG_SLOTS; i++) begin
        prg_slot_page[i] <= PRG_RESET_PAGE;
      end
    end else begin
      if (in_accept && (in_func == FUNC_WRITE)) begin
        if (in_addr == ADDR_SELECT) begin
          command_index <= in_data[CMD_W-1:0];
          prg_swap      <= in_data[SEL_PRG_SWAP_BIT];
          chr_swap      <= in_data[SEL_CHR_SWAP_BIT];
        end else if ((in_addr & MIRROR_MASK) == ADDR_MIRROR) begin
          mirror_bit <= in_data[0];
        end
      end
      // Last remainder step writes the target slot.
      if ((state == ST_DIV) && (step == 3'd7)) begin
        if (is_prg) begin
          prg_slot_page[slot[PRG_SEL_W-1:0]] <= unit_res;
        end else begin
          chr_slot_page[slot] <= unit_res;
        end
      end
      // Neighbor slot gets the next page, wrapped by the count.
      if (state == ST_PAIR) begin
        chr_slot_page[slot + CHR_SEL_W'(1)] <= unit_res;
      end
    end
  end

  // Datapath registers for the remainder sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      if (in_accept) begin
        step     <= '0;
        div_cnt  <= dec_cnt;
        dividend <= in_data;
        rem      <= '0;
        is_prg   <= dec_prg;
        slot     <= dec_slot;
        pair     <= dec_pair;
        res_page <= map_page;
      end else if (state == ST_DIV) begin
        step     <= step + 3'd1;
        dividend <= {dividend[BYTE_W-2:0], 1'b0};
        rem      <= unit_res[BYTE_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b000000, mirror_bit, res_page};
    end
  end

  // Assertions
  a_rem_below_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({3'b000, rem} < div_cnt))
    else $error("partial remainder not below page count");

  a_pair_only_chr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAIR) |-> (pair && !is_prg))
    else $error("pair fill entered for a non-pair command");

  a_map_goes_done: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_func != FUNC_WRITE)) |=> (state == ST_DONE))
    else $error("translation did not go straight to output");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("output became valid outside the done state");

  a_step_zero_at_start: assert property (@(posedge clk) disable iff (rst)
    (in_accept && start_div) |=> ((state == ST_DIV) && (step == 3'd0)))
    else $error("remainder sequence did not start at step zero");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAMBO-1 bank switch mapper testbench
// Drives bus writes and CPU/PPU translations into the mapper over the input
// stream and checks every result against a cycle-free bank model kept in
// the bench. A short directed table comes first, followed by random bank
// programming sequences under several page-count settings, with random
// idle cycles on both stream sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------

module tb_top;
  import rambo1_pkg::*;

  localparam int        CLK_HALF    = 6;
  localparam int        IDLE_LIMIT  = 3000;
  localparam int        LONG_HOLD   = 300;
  localparam int        PHASES      = 6;
  localparam int        PHASE_ITEMS = 215;
  localparam int        DIR_ROWS    = 25;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 4'd12;

  // One result of the mapper: page[8:0], mirroring[9]
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              mirroring;
  } map_result_t;

  // One row of the directed table; the result is used only when fixed is set
  typedef struct packed {
    logic [1:0]        fn;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              fixed;
    map_result_t       result;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [10:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // func[1:0], address[17:2], data[25:18]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // page[8:0], mirroring[9]

  // Bank model state
  logic [CHR_CNT_W-1:0] chr_pages_total;
  logic [PRG_CNT_W-1:0] prg_pages_total;
  logic [CMD_W-1:0]     sel_cmd;
  logic                 prg_swap_q;
  logic                 chr_swap_q;
  logic                 mirror_q;
  logic [PAGE_W-1:0]    chr_bank [CHR_SLOTS];
  logic [PAGE_W-1:0]    prg_bank [PRG_SLOTS];

  map_result_t pending_maps [$];
  int          mismatches;
  int          idle_cycles;
  bit          tx_calm;
  bit          rx_calm;
  bit          rx_hold_req;
  dir_row_t    dir_rows [DIR_ROWS];

  rambo1_bank_switch_mapper u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Loads a character slot, and its neighbor with the next page for pairs.
  function automatic void load_chr_bank(int slot, logic [BYTE_W-1:0] val, bit pair);
    int rem;
    if (chr_pages_total == 0) return;
    rem = int'(val) % int'(chr_pages_total);
    chr_bank[slot & 7] = PAGE_W'(rem);
    if (pair) chr_bank[(slot + 1) & 7] = PAGE_W'((rem + 1) % int'(chr_pages_total));
  endfunction

  function automatic void load_prg_bank(int slot, logic [BYTE_W-1:0] val);
    if (prg_pages_total == 0) return;
    prg_bank[slot & 3] = PAGE_W'(int'(val) % int'(prg_pages_total));
  endfunction

  // Applies one transaction to the bank model and returns its result.
  function automatic map_result_t predict_map(logic [1:0] fn, logic [ADDR_W-1:0] a,
                                              logic [BYTE_W-1:0] d);
    map_result_t r;
    int          cs;
    r.page = '0;
    cs = chr_swap_q ? 4 : 0;
    case (fn)
      FUNC_WRITE: begin
        if (a == ADDR_SELECT) begin
          sel_cmd    = d[CMD_W-1:0];
          prg_swap_q = d[SEL_PRG_SWAP_BIT];
          chr_swap_q = d[SEL_CHR_SWAP_BIT];
        end else if (a == ADDR_DATA) begin
          case (sel_cmd)
            CMD_CHR_PAIR_LO: load_chr_bank(cs, d, 1'b1);
            CMD_CHR_PAIR_HI: load_chr_bank(cs + 2, d, 1'b1);
            CMD_CHR_SINGLE0: load_chr_bank(4 - cs, d, 1'b0);
            CMD_CHR_SINGLE1: load_chr_bank(5 - cs, d, 1'b0);
            CMD_CHR_SINGLE2: load_chr_bank(6 - cs, d, 1'b0);
            CMD_CHR_SINGLE3: load_chr_bank(7 - cs, d, 1'b0);
            CMD_PRG_FIRST:   load_prg_bank(prg_swap_q ? 1 : 0, d);
            CMD_PRG_SECOND:  load_prg_bank(prg_swap_q ? 2 : 1, d);
            CMD_CHR_ODD1:    load_chr_bank(1, d, 1'b0);
            CMD_CHR_ODD3:    load_chr_bank(3, d, 1'b0);
            CMD_PRG_THIRD:   load_prg_bank(prg_swap_q ? 0 : 2, d);
            default: ;
          endcase
        end else if ((a & MIRROR_MASK) == ADDR_MIRROR) begin
          mirror_q = d[0];
        end
      end
      // Reads below 0x8000 are not in cartridge program space.
      FUNC_CPU_MAP: if (a[15]) r.page = prg_bank[a[14:13]];
      FUNC_PPU_MAP: r.page = chr_bank[a[12:10]];
      default: ;
    endcase
    r.mirroring = mirror_q;
    return r;
  endfunction

  // Offers one transaction after a random gap and records its expected result.
  task automatic send_item(logic [1:0] fn, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d,
                           logic fixed, map_result_t fixed_result);
    int          gap;
    map_result_t r;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {6'b0, d, a, fn};
    do @(posedge clk); while (!s_tready);
    r = predict_map(fn, a, d);
    pending_maps.push_back(fixed ? fixed_result : r);
  endtask

  // Stops offering and waits for every outstanding result.
  task automatic wait_all_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [10:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_CHR_COUNT) chr_pages_total = val;
    else prg_pages_total = val[PRG_CNT_W-1:0];
  endtask

  task automatic send_translate();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 1) == 0) begin
      a = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(0, 65535))
                                      : {1'b1, 15'($urandom_range(0, 32767))};
      send_item(FUNC_CPU_MAP, a, 8'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      a = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(0, 65535))
                                      : ADDR_W'($urandom_range(0, 16'h1FFF));
      send_item(FUNC_PPU_MAP, a, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  // Mostly select/data bank programming followed by reads, with some noise.
  task automatic run_random(int n, bit pause_mid);
    int                sent;
    int                r;
    int                k;
    logic [ADDR_W-1:0] a;
    sent = 0;
    while (sent < n) begin
      if (pause_mid && sent >= n / 2) begin
        wait_all_results();
        pause_mid = 1'b0;
      end
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_item(FUNC_WRITE, ADDR_SELECT, 8'($urandom_range(0, 255)), 1'b0, '0);
        send_item(FUNC_WRITE, ADDR_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
        k = $urandom_range(1, 3);
        repeat (k) send_translate();
        sent += 2 + k;
      end else if (r < 78) begin
        a = {4'hA, 12'($urandom_range(0, 4095))};
        send_item(FUNC_WRITE, a, 8'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: a = ADDR_SELECT;
          1: a = ADDR_DATA;
          2: a = ADDR_SELECT + ADDR_W'($urandom_range(0, 3)) - 16'd1;
          default: a = ADDR_W'($urandom_range(0, 65535));
        endcase
        send_item(2'($urandom_range(0, 3)), a, 8'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    map_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected transaction, page %0d mirroring %0b",
                 $time, m_tdata[8:0], m_tdata[9]);
        mismatches++;
      end else begin
        want = pending_maps.pop_front();
        if (m_tdata[8:0] !== want.page) begin
          $display("%0t: page mismatch, expected %0d, actual %0d",
                   $time, want.page, m_tdata[8:0]);
          mismatches++;
        end
        if (m_tdata[9] !== want.mirroring) begin
          $display("%0t: mirroring mismatch, expected %0b, actual %0b",
                   $time, want.mirroring, m_tdata[9]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random stalls per transaction, calm stretches, one long hold
  initial begin
    int n;
    bit hold_used;
    m_tready  = 1'b0;
    rx_calm   = 1'b0;
    hold_used = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      if (rx_hold_req && !hold_used) begin
        hold_used = 1'b1;
        n = LONG_HOLD;
      end else begin
        n = rx_calm ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Directed table, at reset page counts (256 character, 32 program pages)
  initial begin
    dir_rows = '{
      '{FUNC_PPU_MAP, 16'h0000, 8'h00, 1'b1, '{9'd0, 1'b0}},
      '{FUNC_PPU_MAP, 16'h1C00, 8'hFF, 1'b1, '{9'd7, 1'b0}},
      // PPU address above the pattern tables still selects by bits 12..10
      '{FUNC_PPU_MAP, 16'hFFFF, 8'h00, 1'b1, '{9'd7, 1'b0}},
      '{FUNC_CPU_MAP, 16'h8000, 8'h00, 1'b1, '{PRG_RESET_PAGE, 1'b0}},
      '{FUNC_CPU_MAP, 16'hFFFF, 8'hFF, 1'b1, '{PRG_RESET_PAGE, 1'b0}},
      '{FUNC_CPU_MAP, 16'h7FFF, 8'h00, 1'b1, '{9'd0, 1'b0}},
      '{FUNC_UNUSED,  16'hFFFF, 8'hFF, 1'b1, '{9'd0, 1'b0}},
      '{FUNC_WRITE,   ADDR_MIRROR, 8'h01, 1'b1, '{9'd0, 1'b1}},
      '{FUNC_WRITE,   16'hAFFF, 8'hFE, 1'b1, '{9'd0, 1'b0}},
      '{FUNC_WRITE,   16'hA5A5, 8'hFF, 1'b1, '{9'd0, 1'b1}},
      // Pair load with wrap of the neighbor page
      '{FUNC_WRITE,   ADDR_SELECT, {4'h0, CMD_CHR_PAIR_LO}, 1'b0, '0},
      '{FUNC_WRITE,   ADDR_DATA, 8'hFF, 1'b0, '0},
      '{FUNC_PPU_MAP, 16'h0000, 8'h00, 1'b0, '0},
      '{FUNC_PPU_MAP, 16'h0400, 8'h00, 1'b0, '0},
      // Third program slot with both swaps set
      '{FUNC_WRITE,   ADDR_SELECT, {4'hC, CMD_PRG_THIRD}, 1'b0, '0},
      '{FUNC_WRITE,   ADDR_DATA, 8'h25, 1'b0, '0},
      '{FUNC_CPU_MAP, 16'h8000, 8'h00, 1'b0, '0},
      '{FUNC_CPU_MAP, 16'hC000, 8'h00, 1'b0, '0},
      // Unused command and writes outside the decoded addresses
      '{FUNC_WRITE,   ADDR_SELECT, {4'hB, CMD_UNUSED}, 1'b0, '0},
      '{FUNC_WRITE,   ADDR_DATA, 8'h55, 1'b0, '0},
      '{FUNC_WRITE,   16'h8002, 8'hFF, 1'b0, '0},
      '{FUNC_WRITE,   16'hB000, 8'h00, 1'b0, '0},
      '{FUNC_WRITE,   ADDR_SELECT, {4'h4, CMD_CHR_PAIR_HI}, 1'b0, '0},
      '{FUNC_WRITE,   ADDR_DATA, 8'h80, 1'b0, '0},
      '{FUNC_PPU_MAP, 16'h1BFF, 8'h00, 1'b0, '0}
    };
  end

  // Main sequence
  initial begin
    logic [10:0] chr_set [PHASES];
    logic [10:0] prg_set [PHASES];
    cfg_we      = 1'b0;
    cfg_index   = 1'b0;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    tx_calm     = 1'b0;
    rx_hold_req = 1'b0;

    // Bank model after reset
    chr_pages_total = 11'd256;
    prg_pages_total = 9'd32;
    sel_cmd         = '0;
    prg_swap_q      = 1'b0;
    chr_swap_q      = 1'b0;
    mirror_q        = 1'b0;
    for (int i = 0; i < CHR_SLOTS; i++) chr_bank[i] = PAGE_W'(i);
    for (int i = 0; i < PRG_SLOTS; i++) prg_bank[i] = PRG_RESET_PAGE;

    // Page count settings per phase, extremes first
    chr_set = '{11'd2040, 11'd0, 11'd1, 11'd256,
                11'($urandom_range(2, 40)), 11'($urandom_range(0, 2040))};
    prg_set = '{11'd510, 11'd2, 11'd3, 11'd32,
                11'($urandom_range(2, 20)), 11'($urandom_range(2, 510))};

    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].fn, dir_rows[i].addr, dir_rows[i].data,
                dir_rows[i].fixed, dir_rows[i].result);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_all_results();
      repeat (4) @(posedge clk);
      write_cfg(CFG_CHR_COUNT, chr_set[p]);
      write_cfg(CFG_PRG_COUNT, prg_set[p]);
      // One phase stalls the output long enough to back up the input.
      if (p == 3) rx_hold_req = 1'b1;
      run_random(PHASE_ITEMS, p == 1);
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
